[design/wlt_pkg.sv]
// Package for the word list table: field widths, request and error codes,
// the word and cell control types, and word normalisation.
// Depends on nothing; every other file of the block uses it.
package wlt_pkg;

    localparam int CHARS_W   = 64;
    localparam int LEN_W     = 4;
    localparam int POS_W     = 4;
    localparam int REQ_W     = 3;
    localparam int ERR_W     = 3;
    localparam int IDX_OUT_W = 4;
    localparam int CNT_OUT_W = 5;
    localparam int BYTES     = CHARS_W / 8;

    // Request codes carried in req_type.
    typedef enum logic [REQ_W-1:0] {
        REQ_INS_FIRST = 3'd0,
        REQ_INS_LAST  = 3'd1,
        REQ_INS_AT    = 3'd2,
        REQ_DEL_FIRST = 3'd3,
        REQ_DEL_LAST  = 3'd4,
        REQ_DEL_AT    = 3'd5,
        REQ_DEL_WORD  = 3'd6,
        REQ_FIND      = 3'd7
    } req_t;

    // Error codes reported with every result.
    typedef enum logic [ERR_W-1:0] {
        ERR_OK        = 3'd0,
        ERR_FULL      = 3'd1,
        ERR_EMPTY     = 3'd2,
        ERR_POS       = 3'd3,
        ERR_NOT_FOUND = 3'd4
    } err_t;

    // What every cell does with its entry on a write cycle.
    typedef enum logic [1:0] {
        CMD_HOLD,
        CMD_INSERT,
        CMD_REMOVE
    } cmd_kind_t;

    typedef struct packed {
        logic [LEN_W-1:0]   len;
        logic [CHARS_W-1:0] chars;
    } word_t;

    // Control broadcast from the sequencer to the row of cells.
    typedef struct packed {
        logic      cmp_en;
        logic      wr_en;
        cmd_kind_t kind;
        word_t     word;
    } cell_ctrl_t;

    // Saturates the length and clears the character bytes beyond it.
    function automatic word_t norm_word(logic [CHARS_W-1:0] chars,
                                        logic [LEN_W-1:0] len,
                                        logic [LEN_W-1:0] max_len);
        word_t            w;
        logic [LEN_W-1:0] l;
        l = (len > max_len) ? max_len : len;
        w.len = l;
        for (int b = 0; b < BYTES; b++)
        begin
            w.chars[8*b +: 8] = (LEN_W'(b) < l) ? chars[8*b +: 8] : 8'h00;
        end
        return w;
    endfunction

endpackage

[design/wlt_if.sv]
// Valid/ready channel interfaces for the word list table: the request
// channel and the response channel. Depends on wlt_pkg for field widths.

interface wlt_req_if;
    logic                          valid;
    logic                          ready;
    logic [wlt_pkg::REQ_W-1:0]     req_type;
    logic [wlt_pkg::CHARS_W-1:0]   word_chars;
    logic [wlt_pkg::LEN_W-1:0]     word_len;
    logic [wlt_pkg::POS_W-1:0]     position;

    modport source (output valid, req_type, word_chars, word_len, position,
                    input ready);
    modport sink   (input valid, req_type, word_chars, word_len, position,
                    output ready);
endinterface

interface wlt_rsp_if;
    logic                          valid;
    logic                          ready;
    logic [wlt_pkg::CHARS_W-1:0]   out_chars;
    logic [wlt_pkg::LEN_W-1:0]     out_len;
    logic [wlt_pkg::IDX_OUT_W-1:0] out_index;
    logic                          found;
    logic [wlt_pkg::CNT_OUT_W-1:0] entry_count;
    logic [wlt_pkg::ERR_W-1:0]     error_code;

    modport source (output valid, out_chars, out_len, out_index, found,
                    entry_count, error_code, input ready);
    modport sink   (input valid, out_chars, out_len, out_index, found,
                    entry_count, error_code, output ready);
endinterface

[design/wlt_cell.sv]
// One cell of the word list: holds a single entry, compares it with the
// broadcast word and shifts to or from its neighbours. Depends on wlt_pkg.
module wlt_cell #(
    parameter int IDX = 0,
    parameter int IW  = 4,
    parameter int CW  = 5
) (
    input  logic               clk,
    input  wlt_pkg::cell_ctrl_t ctrl,
    input  logic [IW-1:0]      at_idx,
    input  logic [CW-1:0]      count,
    input  wlt_pkg::word_t     lo_in,
    input  wlt_pkg::word_t     hi_in,
    input  logic               seen_in,
    output wlt_pkg::word_t     data,
    output wlt_pkg::word_t     rd_out,
    output logic               seen_out,
    output logic               hit_out
);

    wlt_pkg::word_t data_reg;
    wlt_pkg::word_t data_next;
    logic           match_reg;
    logic           at_here;
    logic           above;
    logic           live;

    assign at_here = (IW'(IDX) == at_idx);
    assign above   = (IW'(IDX) > at_idx);
    assign live    = (CW'(IDX) < count);

    // Next entry value: insert opens a gap by pulling from below,
    // remove closes one by pulling from above.
    always_comb
    begin
        data_next = data_reg;
        case (ctrl.kind)
            wlt_pkg::CMD_INSERT:
            begin
                if (at_here)
                    data_next = ctrl.word;
                else if (above)
                    data_next = lo_in;
            end
            wlt_pkg::CMD_REMOVE:
            begin
                if (at_here || above)
                    data_next = hi_in;
            end
            default:
            begin
                data_next = data_reg;
            end
        endcase
    end

    // Entry storage and the registered match of the live entry.
    always_ff @(posedge clk)
    begin
        if (ctrl.wr_en)
            data_reg <= data_next;
        if (ctrl.cmp_en)
            match_reg <= live && (data_reg == ctrl.word);
    end

    // The first match down the row wins.
    assign seen_out = seen_in | match_reg;
    assign hit_out  = match_reg & ~seen_in;
    assign data     = data_reg;
    assign rd_out   = at_here ? data_reg : '0;

endmodule

[design/word_list_table_core.sv]
// Top level of the word list table: request sequencer, row of cells and
// response register. Depends on wlt_pkg, wlt_if and wlt_cell.
//
// Each request runs as a compare step, then an execute step: in the cycle
// it is accepted every cell compares its entry with the normalised word,
// and in the execute state the sequencer picks the position and all cells
// shift or load at once, with the response written to an output register.
// A new request is taken as soon as the execute cycle has finished, even
// while the previous response still waits; the execute cycle itself waits
// only while a response is held and not taken. The compare result is
// registered in the cells. There is no clearing pass after reset.
module word_list_table_core #(
    parameter int CAPACITY  = 16,
    parameter int MAX_CHARS = 8
) (
    input logic     clk,
    input logic     rst_n,
    wlt_req_if.sink   req,
    wlt_rsp_if.source rsp
);

    localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int PW = (CW > wlt_pkg::CNT_OUT_W) ? CW : wlt_pkg::CNT_OUT_W;

    typedef enum logic {
        ST_IDLE,
        ST_EXEC
    } state_t;

    state_t                        state_reg, state_next;
    wlt_pkg::req_t                 req_reg, req_next;
    wlt_pkg::word_t                word_reg, word_next;
    logic [wlt_pkg::POS_W-1:0]     pos_reg, pos_next;
    logic [CW-1:0]                 count_reg, count_next;
    logic                          out_valid_reg, out_valid_next;
    wlt_pkg::word_t                out_word_reg, out_word_next;
    logic [wlt_pkg::IDX_OUT_W-1:0] out_index_reg, out_index_next;
    logic                          found_reg, found_next;
    logic [wlt_pkg::CNT_OUT_W-1:0] entry_count_reg, entry_count_next;
    wlt_pkg::err_t                 error_reg, error_next;

    logic                accept;
    logic                exec_go;
    wlt_pkg::word_t      in_word;
    wlt_pkg::cell_ctrl_t ctrl;
    wlt_pkg::cmd_kind_t  kind;
    wlt_pkg::err_t       err;
    logic [PW-1:0]       count_pw;
    logic [PW-1:0]       pos_pw;
    logic [PW-1:0]       at_pw;
    logic [PW-1:0]       cnt_after_pw;
    logic [IW-1:0]       at_idx;
    logic [IW-1:0]       hit_idx;
    logic                any_hit;
    wlt_pkg::word_t      rd_word;

    wlt_pkg::word_t      cell_data [CAPACITY];
    wlt_pkg::word_t      cell_rd   [CAPACITY];
    logic [CAPACITY:0]   seen;
    logic [CAPACITY-1:0] hit;

    // Handshake and normalisation of the incoming word.
    assign req.ready = (state_reg == ST_IDLE);
    assign accept    = req.valid && (state_reg == ST_IDLE);
    assign exec_go   = (state_reg == ST_EXEC) && (!out_valid_reg || rsp.ready);
    assign in_word   = wlt_pkg::norm_word(req.word_chars, req.word_len,
                                          wlt_pkg::LEN_W'(MAX_CHARS));

    // Broadcast control to the row of cells.
    always_comb
    begin
        ctrl.cmp_en = accept;
        ctrl.wr_en  = exec_go;
        ctrl.kind   = kind;
        ctrl.word   = (state_reg == ST_IDLE) ? in_word : word_reg;
    end

    // The row of cells, each linked to its neighbours.
    assign seen[0] = 1'b0;
    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        wlt_pkg::word_t lo_w;
        wlt_pkg::word_t hi_w;
        if (i == 0)
        begin : g_lo_edge
            assign lo_w = '0;
        end
        else
        begin : g_lo_link
            assign lo_w = cell_data[i-1];
        end
        if (i == CAPACITY - 1)
        begin : g_hi_edge
            assign hi_w = '0;
        end
        else
        begin : g_hi_link
            assign hi_w = cell_data[i+1];
        end

        wlt_cell #(
            .IDX (i),
            .IW  (IW),
            .CW  (CW)
        ) u_cell (
            .clk      (clk),
            .ctrl     (ctrl),
            .at_idx   (at_idx),
            .count    (count_reg),
            .lo_in    (lo_w),
            .hi_in    (hi_w),
            .seen_in  (seen[i]),
            .data     (cell_data[i]),
            .rd_out   (cell_rd[i]),
            .seen_out (seen[i+1]),
            .hit_out  (hit[i])
        );
    end

    assign any_hit = seen[CAPACITY];

    // Encode the single matching cell and gather the addressed entry.
    always_comb
    begin
        hit_idx = '0;
        rd_word = '0;
        for (int i = 0; i < CAPACITY; i++)
        begin
            if (hit[i])
                hit_idx = hit_idx | IW'(i);
            rd_word = rd_word | cell_rd[i];
        end
    end

    // Target position of the request.
    assign count_pw = PW'(count_reg);
    assign pos_pw   = PW'(pos_reg);

    always_comb
    begin
        case (req_reg)
            wlt_pkg::REQ_INS_FIRST: at_pw = '0;
            wlt_pkg::REQ_INS_LAST:  at_pw = count_pw;
            wlt_pkg::REQ_INS_AT:    at_pw = pos_pw;
            wlt_pkg::REQ_DEL_FIRST: at_pw = '0;
            wlt_pkg::REQ_DEL_LAST:  at_pw = count_pw - PW'(1);
            wlt_pkg::REQ_DEL_AT:    at_pw = pos_pw;
            default:                at_pw = PW'(hit_idx);
        endcase
    end

    assign at_idx = at_pw[IW-1:0];

    // Error checks and the resulting cell command.
    always_comb
    begin
        err  = wlt_pkg::ERR_OK;
        kind = wlt_pkg::CMD_HOLD;
        if (req_reg inside {wlt_pkg::REQ_INS_FIRST, wlt_pkg::REQ_INS_LAST,
                            wlt_pkg::REQ_INS_AT})
        begin
            if (count_pw >= PW'(CAPACITY))
                err = wlt_pkg::ERR_FULL;
            else if (at_pw > count_pw)
                err = wlt_pkg::ERR_POS;
            else
                kind = wlt_pkg::CMD_INSERT;
        end
        else if (req_reg inside {wlt_pkg::REQ_DEL_FIRST, wlt_pkg::REQ_DEL_LAST,
                                 wlt_pkg::REQ_DEL_AT, wlt_pkg::REQ_DEL_WORD})
        begin
            if (count_reg == '0)
                err = wlt_pkg::ERR_EMPTY;
            else if ((req_reg == wlt_pkg::REQ_DEL_AT) && (at_pw >= count_pw))
                err = wlt_pkg::ERR_POS;
            else if ((req_reg == wlt_pkg::REQ_DEL_WORD) && !any_hit)
                err = wlt_pkg::ERR_NOT_FOUND;
            else
                kind = wlt_pkg::CMD_REMOVE;
        end
        else
        begin
            if (!any_hit)
                err = wlt_pkg::ERR_NOT_FOUND;
        end
    end

    always_comb
    begin
        case (kind)
            wlt_pkg::CMD_INSERT: cnt_after_pw = count_pw + PW'(1);
            wlt_pkg::CMD_REMOVE: cnt_after_pw = count_pw - PW'(1);
            default:             cnt_after_pw = count_pw;
        endcase
    end

    // Next values of the sequencer and response registers.
    always_comb
    begin
        state_next       = state_reg;
        req_next         = req_reg;
        word_next        = word_reg;
        pos_next         = pos_reg;
        count_next       = count_reg;
        out_valid_next   = out_valid_reg && !rsp.ready;
        out_word_next    = out_word_reg;
        out_index_next   = out_index_reg;
        found_next       = found_reg;
        entry_count_next = entry_count_reg;
        error_next       = error_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    req_next   = wlt_pkg::req_t'(req.req_type);
                    word_next  = in_word;
                    pos_next   = req.position;
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                if (exec_go)
                begin
                    count_next       = cnt_after_pw[CW-1:0];
                    out_valid_next   = 1'b1;
                    entry_count_next = cnt_after_pw[wlt_pkg::CNT_OUT_W-1:0];
                    error_next       = err;
                    if (err == wlt_pkg::ERR_OK)
                    begin
                        out_word_next  = (kind == wlt_pkg::CMD_INSERT) ? word_reg : rd_word;
                        out_index_next = at_pw[wlt_pkg::IDX_OUT_W-1:0];
                        found_next     = 1'b1;
                    end
                    else
                    begin
                        out_word_next  = '0;
                        out_index_next = '0;
                        found_next     = 1'b0;
                    end
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Sequencer state and registered response.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            count_reg       <= '0;
            out_valid_reg   <= 1'b0;
            req_reg         <= wlt_pkg::REQ_INS_FIRST;
            word_reg        <= '0;
            pos_reg         <= '0;
            out_word_reg    <= '0;
            out_index_reg   <= '0;
            found_reg       <= 1'b0;
            entry_count_reg <= '0;
            error_reg       <= wlt_pkg::ERR_OK;
        end
        else
        begin
            state_reg       <= state_next;
            count_reg       <= count_next;
            out_valid_reg   <= out_valid_next;
            req_reg         <= req_next;
            word_reg        <= word_next;
            pos_reg         <= pos_next;
            out_word_reg    <= out_word_next;
            out_index_reg   <= out_index_next;
            found_reg       <= found_next;
            entry_count_reg <= entry_count_next;
            error_reg       <= error_next;
        end
    end

    // Response channel.
    assign rsp.valid       = out_valid_reg;
    assign rsp.out_chars   = out_word_reg.chars;
    assign rsp.out_len     = out_word_reg.len;
    assign rsp.out_index   = out_index_reg;
    assign rsp.found       = found_reg;
    assign rsp.entry_count = entry_count_reg;
    assign rsp.error_code  = error_reg;

`ifndef SYNTHESIS
    // The list never holds more entries than there are cells.
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(CAPACITY))
        else $error("entry count exceeds capacity");

    // At most one cell may claim the first match.
    a_single_hit: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EXEC) |-> $onehot0(hit))
        else $error("more than one cell claims the first match");

    // Every executed request leaves a response for the sink.
    a_exec_resp: assert property (@(posedge clk) disable iff (!rst_n)
        exec_go |=> rsp.valid)
        else $error("executed request produced no response");

    // A failed request leaves the list length unchanged.
    a_fail_keeps: assert property (@(posedge clk) disable iff (!rst_n)
        (exec_go && (err != wlt_pkg::ERR_OK)) |=> $stable(count_reg))
        else $error("failed request changed the entry count");
`endif

endmodule

[sim/word_list_table_core_test.sv]
// Self-checking testbench for word_list_table_core: directed and random list
// requests, with a shadow list that predicts every response.
// Depends on wlt_pkg, wlt_if and the block's RTL; needs no other input.
module word_list_table_core_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int LIST_DEPTH = 16;
    localparam int WORD_MAX   = 8;
    localparam int POOL_SIZE  = 6;
    localparam int PHASE_LEN  = 250;

    // One response as the block should report it.
    typedef struct {
        logic [wlt_pkg::CHARS_W-1:0]   chars;
        logic [wlt_pkg::LEN_W-1:0]     len;
        logic [wlt_pkg::IDX_OUT_W-1:0] index;
        logic                          found;
        logic [wlt_pkg::CNT_OUT_W-1:0] count;
        wlt_pkg::err_t                 err;
    } list_result_t;

    // Shadow copy of the word list. Each accepted request is applied to it
    // and the response it should give is queued; responses from the block
    // are checked against the oldest queued one.
    class list_shadow;
        logic [wlt_pkg::CHARS_W-1:0] entry_chars[LIST_DEPTH];
        logic [wlt_pkg::LEN_W-1:0]   entry_len[LIST_DEPTH];
        int                          n_entries;
        list_result_t                pending_results[$];
        int                          n_checked;
        int                          n_fail;
        int                          n_by_err[5];

        function new();
            n_entries = 0;
            n_checked = 0;
            n_fail    = 0;
            foreach (n_by_err[i])
            begin
                n_by_err[i] = 0;
            end
        endfunction

        // First position holding the word, or the entry count when absent.
        function int locate(logic [wlt_pkg::CHARS_W-1:0] chars,
                            logic [wlt_pkg::LEN_W-1:0] len);
            for (int i = 0; i < n_entries; i++)
            begin
                if (entry_len[i] == len && entry_chars[i] == chars)
                begin
                    return i;
                end
            end
            return n_entries;
        endfunction

        // Fills the word fields of a response from a live entry.
        function void take_entry(int at, ref list_result_t r);
            r.chars = entry_chars[at];
            r.len   = entry_len[at];
            r.index = wlt_pkg::IDX_OUT_W'(at);
            r.found = 1'b1;
        endfunction

        function void note_request(wlt_pkg::req_t kind,
                                   logic [wlt_pkg::CHARS_W-1:0] chars,
                                   logic [wlt_pkg::LEN_W-1:0] len,
                                   logic [wlt_pkg::POS_W-1:0] pos);
            logic [wlt_pkg::LEN_W-1:0]   l;
            logic [wlt_pkg::CHARS_W-1:0] c;
            int                          at;
            list_result_t                r;
            // Saturate the length and clear the bytes past it.
            l = (len > WORD_MAX) ? wlt_pkg::LEN_W'(WORD_MAX) : len;
            c = chars;
            for (int b = int'(l); b < wlt_pkg::BYTES; b++)
            begin
                c[8*b +: 8] = 8'h00;
            end
            r.chars = '0;
            r.len   = '0;
            r.index = '0;
            r.found = 1'b0;
            r.err   = wlt_pkg::ERR_OK;
            case (kind)
                wlt_pkg::REQ_INS_FIRST, wlt_pkg::REQ_INS_LAST, wlt_pkg::REQ_INS_AT:
                begin
                    if (kind == wlt_pkg::REQ_INS_FIRST)
                        at = 0;
                    else if (kind == wlt_pkg::REQ_INS_LAST)
                        at = n_entries;
                    else
                        at = int'(pos);
                    if (n_entries >= LIST_DEPTH)
                        r.err = wlt_pkg::ERR_FULL;
                    else if (at > n_entries)
                        r.err = wlt_pkg::ERR_POS;
                    else
                    begin
                        for (int i = n_entries; i > at; i--)
                        begin
                            entry_chars[i] = entry_chars[i-1];
                            entry_len[i]   = entry_len[i-1];
                        end
                        entry_chars[at] = c;
                        entry_len[at]   = l;
                        n_entries++;
                        take_entry(at, r);
                    end
                end
                wlt_pkg::REQ_FIND:
                begin
                    at = locate(c, l);
                    if (at >= n_entries)
                        r.err = wlt_pkg::ERR_NOT_FOUND;
                    else
                        take_entry(at, r);
                end
                default:
                begin
                    // All the delete requests.
                    if (n_entries == 0)
                        r.err = wlt_pkg::ERR_EMPTY;
                    else
                    begin
                        case (kind)
                            wlt_pkg::REQ_DEL_FIRST: at = 0;
                            wlt_pkg::REQ_DEL_LAST:  at = n_entries - 1;
                            wlt_pkg::REQ_DEL_AT:    at = int'(pos);
                            default:                at = locate(c, l);
                        endcase
                        if (at >= n_entries)
                            r.err = (kind == wlt_pkg::REQ_DEL_AT) ? wlt_pkg::ERR_POS
                                                                  : wlt_pkg::ERR_NOT_FOUND;
                        else
                        begin
                            take_entry(at, r);
                            for (int i = at; i + 1 < n_entries; i++)
                            begin
                                entry_chars[i] = entry_chars[i+1];
                                entry_len[i]   = entry_len[i+1];
                            end
                            n_entries--;
                        end
                    end
                end
            endcase
            r.count = wlt_pkg::CNT_OUT_W'(n_entries);
            pending_results.push_back(r);
        endfunction

        function void compare_field(string name, logic [63:0] want, logic [63:0] got);
            if (got !== want)
            begin
                $display("%0t: %s mismatch: expected %0h, actual %0h",
                         $time, name, want, got);
                n_fail++;
            end
        endfunction

        function void check_response(list_result_t got);
            list_result_t want;
            if (pending_results.size() == 0)
            begin
                $display("%0t: response with nothing expected: chars %0h len %0d err %0d",
                         $time, got.chars, got.len, got.err);
                n_fail++;
                return;
            end
            want = pending_results.pop_front();
            n_checked++;
            n_by_err[int'(want.err)]++;
            compare_field("out_chars", want.chars, got.chars);
            compare_field("out_len", 64'(want.len), 64'(got.len));
            compare_field("out_index", 64'(want.index), 64'(got.index));
            compare_field("found", 64'(want.found), 64'(got.found));
            compare_field("entry_count", 64'(want.count), 64'(got.count));
            compare_field("error_code", 64'(want.err), 64'(got.err));
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n;

    wlt_req_if req_bus ();
    wlt_rsp_if rsp_bus ();

    word_list_table_core #(
        .CAPACITY  (LIST_DEPTH),
        .MAX_CHARS (WORD_MAX)
    ) u_top (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_bus),
        .rsp   (rsp_bus)
    );

    list_shadow                  board = new();
    int                          send_idle_pct;
    int                          stall_pct;
    int                          n_sent;
    bit                          grow;
    logic [wlt_pkg::CHARS_W-1:0] pool_chars[POOL_SIZE];
    logic [wlt_pkg::LEN_W-1:0]   pool_len[POOL_SIZE];

    // Clock, 10 ns period.
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Response side: take or stall at random.
    always @(posedge clk)
    begin
        rsp_bus.ready <= ($urandom_range(99) >= stall_pct);
    end

    // Watch both channels; values seen here are those before the edge.
    always @(posedge clk)
    begin
        list_result_t got;
        if (rst_n)
        begin
            if (req_bus.valid && req_bus.ready)
            begin
                board.note_request(wlt_pkg::req_t'(req_bus.req_type), req_bus.word_chars,
                                   req_bus.word_len, req_bus.position);
            end
            if (rsp_bus.valid && rsp_bus.ready)
            begin
                got.chars = rsp_bus.out_chars;
                got.len   = rsp_bus.out_len;
                got.index = rsp_bus.out_index;
                got.found = rsp_bus.found;
                got.count = rsp_bus.entry_count;
                got.err   = wlt_pkg::err_t'(rsp_bus.error_code);
                board.check_response(got);
            end
        end
    end

    // Presents one request, with a random gap first, and waits for the transaction.
    task automatic send_request(wlt_pkg::req_t kind,
                                logic [wlt_pkg::CHARS_W-1:0] chars,
                                logic [wlt_pkg::LEN_W-1:0] len,
                                logic [wlt_pkg::POS_W-1:0] pos);
        while ($urandom_range(99) < send_idle_pct)
        begin
            req_bus.valid <= 1'b0;
            @(posedge clk);
        end
        req_bus.valid      <= 1'b1;
        req_bus.req_type   <= kind;
        req_bus.word_chars <= chars;
        req_bus.word_len   <= len;
        req_bus.position   <= pos;
        @(posedge clk);
        while (!req_bus.ready)
        begin
            @(posedge clk);
        end
        n_sent++;
    endtask

    // Holds the request side idle until every expected response has come.
    task automatic drain_responses();
        req_bus.valid <= 1'b0;
        @(posedge clk);
        while (board.pending_results.size() != 0)
        begin
            @(posedge clk);
        end
    endtask

    // One random request. The mix leans towards inserts while the list
    // fills and towards deletes while it empties, so that both the full
    // and the empty list are visited often.
    task automatic random_request();
        int                          r;
        int                          k;
        wlt_pkg::req_t               kind;
        logic [wlt_pkg::CHARS_W-1:0] chars;
        logic [wlt_pkg::CHARS_W-1:0] junk;
        logic [wlt_pkg::LEN_W-1:0]   len;
        logic [wlt_pkg::POS_W-1:0]   pos;
        if (grow && board.n_entries == LIST_DEPTH && $urandom_range(3) == 0)
            grow = 1'b0;
        else if (!grow && board.n_entries == 0 && $urandom_range(3) == 0)
            grow = 1'b1;
        r = $urandom_range(99);
        if (r < 8)
        begin
            // Noise: every field at random.
            send_request(wlt_pkg::req_t'($urandom_range(7)), {$urandom, $urandom},
                         wlt_pkg::LEN_W'($urandom_range(15)),
                         wlt_pkg::POS_W'($urandom_range(15)));
            return;
        end
        r = $urandom_range(99);
        if (r < 15)
            kind = wlt_pkg::REQ_FIND;
        else if (r < (grow ? 72 : 38))
            kind = wlt_pkg::req_t'($urandom_range(2));
        else
            kind = wlt_pkg::req_t'($urandom_range(6, 3));
        // Words mostly come from a small pool so that searches hit, with
        // junk in the bytes past the length and over-long lengths now and then.
        k     = $urandom_range(POOL_SIZE - 1);
        chars = pool_chars[k];
        len   = pool_len[k];
        if ($urandom_range(1) == 1)
        begin
            junk = {$urandom, $urandom};
            for (int b = 0; b < int'(len); b++)
            begin
                junk[8*b +: 8] = 8'h00;
            end
            chars = chars | junk;
        end
        if (len == WORD_MAX && $urandom_range(1) == 1)
            len = wlt_pkg::LEN_W'($urandom_range(15, WORD_MAX));
        if ($urandom_range(9) < 7)
            pos = wlt_pkg::POS_W'($urandom_range(board.n_entries));
        else
            pos = wlt_pkg::POS_W'($urandom_range(15));
        send_request(kind, chars, len, pos);
    endtask

    initial
    begin
        rst_n              = 1'b0;
        req_bus.valid      = 1'b0;
        req_bus.req_type   = wlt_pkg::REQ_FIND;
        req_bus.word_chars = '0;
        req_bus.word_len   = '0;
        req_bus.position   = '0;
        rsp_bus.ready      = 1'b0;
        send_idle_pct      = 0;
        stall_pct          = 0;
        n_sent             = 0;
        grow               = 1'b1;
        for (int k = 0; k < POOL_SIZE; k++)
        begin
            pool_len[k]   = (k == 0) ? wlt_pkg::LEN_W'(0)
                          : (k == 1) ? wlt_pkg::LEN_W'(WORD_MAX)
                                     : wlt_pkg::LEN_W'($urandom_range(WORD_MAX));
            pool_chars[k] = {$urandom, $urandom};
            for (int b = int'(pool_len[k]); b < wlt_pkg::BYTES; b++)
            begin
                pool_chars[k][8*b +: 8] = 8'h00;
            end
        end
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part: every request but insert-last on an empty list,
        // saturated and empty words, appending through insert-at, matching that
        // ignores junk bytes and needs equal lengths, and every bad position.
        send_request(wlt_pkg::REQ_FIND, 64'h0, 4'd0, 4'd0);
        send_request(wlt_pkg::REQ_DEL_FIRST, 64'h0, 4'd0, 4'd0);
        send_request(wlt_pkg::REQ_DEL_LAST, 64'h0, 4'd0, 4'd0);
        send_request(wlt_pkg::REQ_DEL_AT, 64'h0, 4'd0, 4'd0);
        send_request(wlt_pkg::REQ_DEL_WORD, 64'h0, 4'd0, 4'd0);
        send_request(wlt_pkg::REQ_INS_AT, 64'h41, 4'd1, 4'd1);
        send_request(wlt_pkg::REQ_INS_FIRST, 64'hFFFF_FFFF_FFFF_FFFF, 4'd15, 4'd15);
        send_request(wlt_pkg::REQ_INS_LAST, 64'hFFFF_FFFF_FFFF_FFFF, 4'd0, 4'd0);
        send_request(wlt_pkg::REQ_INS_AT, 64'hDEAD_BEEF_0000_6261, 4'd2, 4'd2);
        send_request(wlt_pkg::REQ_INS_AT, 64'h0000_0000_0063_6261, 4'd3, 4'd1);
        send_request(wlt_pkg::REQ_INS_FIRST, 64'h7A, 4'd1, 4'd0);
        send_request(wlt_pkg::REQ_FIND, 64'h1234_5678_9ABC_6261, 4'd2, 4'd0);
        send_request(wlt_pkg::REQ_FIND, 64'h0000_0000_0000_6261, 4'd3, 4'd0);
        send_request(wlt_pkg::REQ_DEL_WORD, 64'h5555_AAAA_5555_AAAA, 4'd0, 4'd0);
        send_request(wlt_pkg::REQ_DEL_AT, 64'h0, 4'd0, 4'd15);
        send_request(wlt_pkg::REQ_DEL_AT, 64'h0, 4'd0, 4'd4);
        send_request(wlt_pkg::REQ_FIND, 64'h0000_0000_0000_FFFF, 4'd9, 4'd0);
        send_request(wlt_pkg::REQ_DEL_AT, 64'h0, 4'd0, 4'd1);
        send_request(wlt_pkg::REQ_DEL_WORD, 64'h0000_0000_0000_0071, 4'd1, 4'd0);
        send_request(wlt_pkg::REQ_INS_AT, 64'h31, 4'd1, 4'd15);
        send_request(wlt_pkg::REQ_DEL_LAST, 64'h0, 4'd0, 4'd0);
        send_request(wlt_pkg::REQ_DEL_FIRST, 64'h0, 4'd0, 4'd0);
        send_request(wlt_pkg::REQ_DEL_WORD, 64'hFFFF_FFFF_FFFF_FFFF, 4'd12, 4'd0);
        drain_responses();

        // Random part in four idling phases, each paused halfway and at its
        // end until every response is back.
        for (int ph = 0; ph < 4; ph++)
        begin
            send_idle_pct = (ph == 1) ? 78 : (ph == 3) ? 26 : 0;
            stall_pct     = (ph == 2) ? 78 : (ph == 3) ? 26 : 0;
            for (int i = 0; i < PHASE_LEN; i++)
            begin
                random_request();
                if (i == PHASE_LEN / 2)
                    drain_responses();
            end
            drain_responses();
        end
        repeat (8) @(posedge clk);

        $display("Sent %0d requests and checked %0d responses over four idling phases.",
                 n_sent, board.n_checked);
        $display("Outcomes: %0d ok, %0d full, %0d empty, %0d bad position, %0d not found.",
                 board.n_by_err[wlt_pkg::ERR_OK], board.n_by_err[wlt_pkg::ERR_FULL],
                 board.n_by_err[wlt_pkg::ERR_EMPTY], board.n_by_err[wlt_pkg::ERR_POS],
                 board.n_by_err[wlt_pkg::ERR_NOT_FOUND]);
        if (board.n_fail == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

    // Watchdog: far beyond the slowest correct run.
    initial
    begin
        #2_000_000;
        $display("Timeout with %0d responses outstanding.", board.pending_results.size());
        $display("CHECKS FAILED");
        $finish;
    end

endmodule

[word_list_table_core.f]
design/wlt_pkg.sv
design/wlt_if.sv
design/wlt_cell.sv
design/word_list_table_core.sv
sim/word_list_table_core_test.sv
